// File: sv/wfbm_pkg.sv
`default_nettype none
package wfbm_pkg;

	// field widths
	localparam int TS_W = 64;
	localparam int LEN_W = 16;
	localparam int CFG_W = 32;
	localparam int SCALE_W = 24;
	localparam int RATE_W = 48;
	localparam int SUM_W = 48;

	// multiply is done in chunks of the byte sum, one scale-wide chunk per cycle
	localparam int CHUNKS = (SUM_W + SCALE_W - 1) / SCALE_W;
	localparam int CHUNK_IW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int PAD_W = CHUNKS * SCALE_W;
	localparam int PROD_W = SUM_W + SCALE_W;
	localparam int NUM_W = PROD_W + 1;
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// register reset values
	localparam logic [CFG_W-1:0] WINDOW_USEC_RST = CFG_W'(1000000);
	localparam logic [CFG_W-1:0] MIN_SPAN_USEC_RST = CFG_W'(900000);
	localparam logic [SCALE_W-1:0] RATE_SCALE_RST = SCALE_W'(800000);

	localparam logic FUNC_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		CFG_WINDOW_USEC = 2'd0,
		CFG_MIN_SPAN_USEC = 2'd1,
		CFG_RATE_SCALE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RSEL_UP = 2'd0,
		RSEL_DOWN = 2'd1,
		RSEL_TOTAL = 2'd2
	} rsel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DLOAD,
		ST_DSTEP,
		ST_DSTORE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic mul_step;
		logic [CHUNK_IW-1:0] mul_idx;
		logic div_load;
		logic div_step;
		logic div_store;
		rsel_t rsel;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic close;
		logic special;
		logic out_full;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: sv/wfbm_ctrl.sv
`default_nettype none
module wfbm_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire wfbm_pkg::dp_stat_t stat,
	output wfbm_pkg::dp_cmd_t cmd
);

	wfbm_pkg::state_t state_q, state_d;
	logic [wfbm_pkg::CNT_W-1:0] cnt_q, cnt_d;
	wfbm_pkg::rsel_t rsel_q, rsel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wfbm_pkg::ST_IDLE;
			cnt_q <= '0;
			rsel_q <= wfbm_pkg::RSEL_UP;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			rsel_q <= rsel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		rsel_d = rsel_q;
		in_stall = 1'b1;
		cmd = '0;
		cmd.mul_idx = cnt_q[wfbm_pkg::CHUNK_IW-1:0];
		cmd.rsel = rsel_q;
		case (state_q)
			wfbm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.close) begin
						state_d = wfbm_pkg::ST_MUL;
						cnt_d = wfbm_pkg::CNT_W'(wfbm_pkg::CHUNKS - 1);
					end
				end
			end
			wfbm_pkg::ST_MUL: begin
				// invalid or zero span needs no division
				if (stat.special) begin
					state_d = wfbm_pkg::ST_OUT;
				end else begin
					cmd.mul_step = 1'b1;
					if (cnt_q == '0) begin
						state_d = wfbm_pkg::ST_DLOAD;
						rsel_d = wfbm_pkg::RSEL_UP;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			wfbm_pkg::ST_DLOAD: begin
				cmd.div_load = 1'b1;
				cnt_d = wfbm_pkg::CNT_W'(wfbm_pkg::NUM_W - 1);
				state_d = wfbm_pkg::ST_DSTEP;
			end
			wfbm_pkg::ST_DSTEP: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = wfbm_pkg::ST_DSTORE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			wfbm_pkg::ST_DSTORE: begin
				cmd.div_store = 1'b1;
				case (rsel_q)
					wfbm_pkg::RSEL_UP: begin
						rsel_d = wfbm_pkg::RSEL_DOWN;
						state_d = wfbm_pkg::ST_DLOAD;
					end
					wfbm_pkg::RSEL_DOWN: begin
						rsel_d = wfbm_pkg::RSEL_TOTAL;
						state_d = wfbm_pkg::ST_DLOAD;
					end
					default: begin
						state_d = wfbm_pkg::ST_OUT;
					end
				endcase
			end
			wfbm_pkg::ST_OUT: begin
				if (!stat.out_full) begin
					cmd.out_load = 1'b1;
					state_d = wfbm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wfbm_pkg::ST_IDLE;
			end
		endcase
	end

	a_close_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wfbm_pkg::ST_IDLE && in_valid && stat.close)
		|=> (state_q == wfbm_pkg::ST_MUL))
		else $error("window close did not start the rate computation");

	a_total_ends_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wfbm_pkg::ST_DSTORE && rsel_q == wfbm_pkg::RSEL_TOTAL)
		|=> (state_q == wfbm_pkg::ST_OUT))
		else $error("total rate store did not move to output");

endmodule
`default_nettype wire

// File: sv/wfbm_dpath.sv
`default_nettype none
module wfbm_dpath (
	input wire logic clk,
	input wire logic arst_n,
	input wire wfbm_pkg::dp_cmd_t cmd,
	output wfbm_pkg::dp_stat_t stat,
	input wire logic [wfbm_pkg::CFG_W-1:0] window_usec,
	input wire logic [wfbm_pkg::CFG_W-1:0] min_span_usec,
	input wire logic [wfbm_pkg::SCALE_W-1:0] rate_scale,
	input wire logic func,
	input wire logic [wfbm_pkg::TS_W-1:0] timestamp_usec,
	input wire logic [wfbm_pkg::LEN_W-1:0] packet_bytes,
	input wire logic upstream,
	output logic out_valid,
	input wire logic out_stall,
	output logic [wfbm_pkg::TS_W-1:0] mid_time_usec,
	output logic [wfbm_pkg::RATE_W-1:0] rate_upstream,
	output logic [wfbm_pkg::RATE_W-1:0] rate_downstream,
	output logic [wfbm_pkg::RATE_W-1:0] rate_total,
	output logic span_valid
);

	localparam int TS_W = wfbm_pkg::TS_W;
	localparam int SUM_W = wfbm_pkg::SUM_W;
	localparam int SCALE_W = wfbm_pkg::SCALE_W;
	localparam int PROD_W = wfbm_pkg::PROD_W;
	localparam int NUM_W = wfbm_pkg::NUM_W;
	localparam int RATE_W = wfbm_pkg::RATE_W;
	localparam int PAD_W = wfbm_pkg::PAD_W;

	// running window
	logic open_q;
	logic [TS_W-1:0] win_start_q, win_last_q;
	logic [SUM_W-1:0] up_sum_q, down_sum_q;

	// closed window
	logic [TS_W-1:0] snap_start_q, snap_span_q;
	logic [SUM_W-1:0] snap_up_q, snap_down_q;

	logic [PROD_W-1:0] prod_up_q, prod_down_q;
	logic [NUM_W-1:0] num_q, quo_q;
	logic [TS_W-1:0] rem_q;
	logic [RATE_W-1:0] rate_up_q, rate_down_q, rate_tot_q;

	logic out_valid_q;
	logic [TS_W-1:0] out_time_q;
	logic [RATE_W-1:0] out_up_q, out_down_q, out_tot_q;
	logic out_span_ok_q;

	// close detection
	logic [TS_W-1:0] ts_diff;
	logic ts_gap, is_flush, close, reopen;

	assign ts_diff = timestamp_usec - win_start_q;
	assign ts_gap = ts_diff >= TS_W'(window_usec);
	assign is_flush = (func == wfbm_pkg::FUNC_FLUSH);
	assign close = is_flush ? open_q : (open_q && ts_gap);
	assign reopen = !open_q || close;

	// saturating byte accumulate
	logic [SUM_W-1:0] base_up, base_down, add_base, add_sat;
	logic [SUM_W:0] add_sum;

	assign base_up = reopen ? '0 : up_sum_q;
	assign base_down = reopen ? '0 : down_sum_q;
	assign add_base = upstream ? base_up : base_down;
	assign add_sum = {1'b0, add_base} + (SUM_W + 1)'(packet_bytes);
	assign add_sat = add_sum[SUM_W] ? wfbm_pkg::SUM_MAX : add_sum[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			win_start_q <= '0;
			win_last_q <= '0;
			up_sum_q <= '0;
			down_sum_q <= '0;
		end else if (cmd.accept) begin
			if (is_flush) begin
				open_q <= 1'b0;
			end else begin
				open_q <= 1'b1;
				win_last_q <= timestamp_usec;
				if (reopen) begin
					win_start_q <= timestamp_usec;
				end
				up_sum_q <= upstream ? add_sat : base_up;
				down_sum_q <= upstream ? base_down : add_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && close) begin
			snap_start_q <= win_start_q;
			snap_span_q <= win_last_q - win_start_q;
			snap_up_q <= up_sum_q;
			snap_down_q <= down_sum_q;
		end
	end

	// span checks
	logic span_ok, span_zero, nz_up, nz_down;

	assign span_ok = snap_span_q >= TS_W'(min_span_usec);
	assign span_zero = (snap_span_q == '0);
	assign nz_up = (snap_up_q != '0) && (rate_scale != '0);
	assign nz_down = (snap_down_q != '0) && (rate_scale != '0);

	// chunked multiply, top chunk first
	logic [PAD_W-1:0] up_pad, down_pad;
	logic [SCALE_W-1:0] chunk_up, chunk_down;
	logic [2*SCALE_W-1:0] pp_up, pp_down;
	logic mul_first;

	assign up_pad = PAD_W'(snap_up_q);
	assign down_pad = PAD_W'(snap_down_q);
	assign chunk_up = up_pad[cmd.mul_idx * SCALE_W +: SCALE_W];
	assign chunk_down = down_pad[cmd.mul_idx * SCALE_W +: SCALE_W];
	assign pp_up = {{SCALE_W{1'b0}}, chunk_up} * {{SCALE_W{1'b0}}, rate_scale};
	assign pp_down = {{SCALE_W{1'b0}}, chunk_down} * {{SCALE_W{1'b0}}, rate_scale};
	assign mul_first = (cmd.mul_idx == wfbm_pkg::CHUNK_IW'(wfbm_pkg::CHUNKS - 1));

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			prod_up_q <= (mul_first ? '0 : (prod_up_q << SCALE_W)) + PROD_W'(pp_up);
			prod_down_q <= (mul_first ? '0 : (prod_down_q << SCALE_W)) + PROD_W'(pp_down);
		end
	end

	// restoring division, one quotient bit per cycle
	logic [NUM_W-1:0] prod_sum, num_sel;
	logic [TS_W:0] div_trial, div_diff;
	logic div_ge;
	logic round_up;
	logic [NUM_W:0] quo_round;
	logic [RATE_W-1:0] quo_sat;

	assign prod_sum = {1'b0, prod_up_q} + {1'b0, prod_down_q};
	assign div_trial = {rem_q, num_q[NUM_W-1]};
	assign div_ge = div_trial >= {1'b0, snap_span_q};
	assign div_diff = div_trial - {1'b0, snap_span_q};
	// round half up: remainder at least half the divisor
	assign round_up = {rem_q, 1'b0} >= {1'b0, snap_span_q};
	assign quo_round = {1'b0, quo_q} + (NUM_W + 1)'(round_up);
	assign quo_sat = (quo_round > (NUM_W + 1)'(wfbm_pkg::RATE_MAX)) ?
		wfbm_pkg::RATE_MAX : quo_round[RATE_W-1:0];

	always_comb begin
		case (cmd.rsel)
			wfbm_pkg::RSEL_UP: num_sel = {1'b0, prod_up_q};
			wfbm_pkg::RSEL_DOWN: num_sel = {1'b0, prod_down_q};
			default: num_sel = prod_sum;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q <= num_sel;
			quo_q <= '0;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[NUM_W-2:0], div_ge};
			rem_q <= div_ge ? div_diff[TS_W-1:0] : div_trial[TS_W-1:0];
		end
		if (cmd.div_store) begin
			case (cmd.rsel)
				wfbm_pkg::RSEL_UP: rate_up_q <= quo_sat;
				wfbm_pkg::RSEL_DOWN: rate_down_q <= quo_sat;
				default: rate_tot_q <= quo_sat;
			endcase
		end
	end

	// output register
	logic [RATE_W-1:0] fin_up, fin_down, fin_tot;

	always_comb begin
		if (!span_ok) begin
			fin_up = '0;
			fin_down = '0;
			fin_tot = '0;
		end else if (span_zero) begin
			fin_up = nz_up ? wfbm_pkg::RATE_MAX : '0;
			fin_down = nz_down ? wfbm_pkg::RATE_MAX : '0;
			fin_tot = (nz_up || nz_down) ? wfbm_pkg::RATE_MAX : '0;
		end else begin
			fin_up = rate_up_q;
			fin_down = rate_down_q;
			fin_tot = rate_tot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_time_q <= snap_start_q + (snap_span_q >> 1);
			out_up_q <= fin_up;
			out_down_q <= fin_down;
			out_tot_q <= fin_tot;
			out_span_ok_q <= span_ok;
		end
	end

	assign stat.close = close;
	assign stat.special = !span_ok || span_zero;
	assign stat.out_full = out_valid_q;

	assign out_valid = out_valid_q;
	assign mid_time_usec = out_time_q;
	assign rate_upstream = out_up_q;
	assign rate_downstream = out_down_q;
	assign rate_total = out_tot_q;
	assign span_valid = out_span_ok_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q)
		else $error("result loaded over a pending transfer");

	a_total_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_tot_q >= out_up_q && out_tot_q >= out_down_q))
		else $error("total rate below a directional rate");

	a_packet_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !is_flush) |=> open_q)
		else $error("packet left no window open");

endmodule
`default_nettype wire

// File: sv/windowed_flow_bandwidth_meter.sv
`default_nettype none
// windowed flow bandwidth meter: packet records of one flow (timestamp, length, direction)
// are grouped into time windows; a packet at least window_usec after the window start, or a
// flush record, closes the window and produces one transfer on the output channel holding the
// window midpoint, the up, down and total rates (bytes * rate_scale / span, rounded half up,
// saturated at 2^48-1) and a span_valid flag (span >= min_span_usec, rates forced to zero
// otherwise). a record that closes no window is taken without a stall. a record that closes a
// window holds the input stalled while the rates are formed: 24x24 partial products, one per
// chunk of the sums, then three restoring divisions through one shared 65-bit subtractor; a
// window with an invalid or zero span skips the division. the output register lets the next
// records in while a result waits to be taken. the user must write the registers only while
// the block is idle; the block itself does not enforce this.
module windowed_flow_bandwidth_meter (
	input wire logic clk,
	input wire logic arst_n,
	// configuration write port
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [wfbm_pkg::CFG_W-1:0] cfg_data,
	// packet record channel
	input wire logic in_valid,
	output logic in_stall,
	input wire logic func,
	input wire logic [wfbm_pkg::TS_W-1:0] timestamp_usec,
	input wire logic [wfbm_pkg::LEN_W-1:0] packet_bytes,
	input wire logic upstream,
	// result channel
	output logic out_valid,
	input wire logic out_stall,
	output logic [wfbm_pkg::TS_W-1:0] mid_time_usec,
	output logic [wfbm_pkg::RATE_W-1:0] rate_upstream,
	output logic [wfbm_pkg::RATE_W-1:0] rate_downstream,
	output logic [wfbm_pkg::RATE_W-1:0] rate_total,
	output logic span_valid
);

	// configuration registers
	logic [wfbm_pkg::CFG_W-1:0] window_usec_q;
	logic [wfbm_pkg::CFG_W-1:0] min_span_usec_q;
	logic [wfbm_pkg::SCALE_W-1:0] rate_scale_q;

	wfbm_pkg::dp_cmd_t cmd;
	wfbm_pkg::dp_stat_t stat;

	// index beyond the register list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_usec_q <= wfbm_pkg::WINDOW_USEC_RST;
			min_span_usec_q <= wfbm_pkg::MIN_SPAN_USEC_RST;
			rate_scale_q <= wfbm_pkg::RATE_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wfbm_pkg::CFG_WINDOW_USEC: window_usec_q <= cfg_data;
				wfbm_pkg::CFG_MIN_SPAN_USEC: min_span_usec_q <= cfg_data;
				wfbm_pkg::CFG_RATE_SCALE: rate_scale_q <= cfg_data[wfbm_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: accept, multiply, three divisions (both skipped for an invalid or zero span), output load
	wfbm_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat (stat),
		.cmd (cmd)
	);

	// window accumulators, multiplier, divider and output register
	wfbm_dpath u_dpath (
		.clk (clk),
		.arst_n (arst_n),
		.cmd (cmd),
		.stat (stat),
		.window_usec (window_usec_q),
		.min_span_usec (min_span_usec_q),
		.rate_scale (rate_scale_q),
		.func (func),
		.timestamp_usec (timestamp_usec),
		.packet_bytes (packet_bytes),
		.upstream (upstream),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mid_time_usec (mid_time_usec),
		.rate_upstream (rate_upstream),
		.rate_downstream (rate_downstream),
		.rate_total (rate_total),
		.span_valid (span_valid)
	);

endmodule
`default_nettype wire

// File: tb/meter_checker.sv
// watches both channels of the bandwidth meter, predicts every closed window and
// compares each result transfer with the oldest prediction
module meter_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [wfbm_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input logic func,
	input logic [wfbm_pkg::TS_W-1:0] timestamp_usec,
	input logic [wfbm_pkg::LEN_W-1:0] packet_bytes,
	input logic upstream,
	input logic out_valid,
	input logic out_stall,
	input logic [wfbm_pkg::TS_W-1:0] mid_time_usec,
	input logic [wfbm_pkg::RATE_W-1:0] rate_upstream,
	input logic [wfbm_pkg::RATE_W-1:0] rate_downstream,
	input logic [wfbm_pkg::RATE_W-1:0] rate_total,
	input logic span_valid,
	output int fail_count,
	output int outstanding
);
	import wfbm_pkg::*;

	typedef struct packed {
		logic [TS_W-1:0] mid;
		logic [RATE_W-1:0] up;
		logic [RATE_W-1:0] down;
		logic [RATE_W-1:0] total;
		logic valid;
	} window_rates_t;

	// shadow registers
	logic [CFG_W-1:0] window_len;
	logic [CFG_W-1:0] min_span;
	logic [SCALE_W-1:0] scale;

	// shadow window state
	logic [TS_W-1:0] win_start;
	logic [TS_W-1:0] win_last;
	logic [SUM_W-1:0] up_bytes;
	logic [SUM_W-1:0] down_bytes;
	logic win_open;

	window_rates_t pending_windows[$];
	window_rates_t got;
	window_rates_t want;
	int fails = 0;

	// bytes * scale / span, rounded half up, saturated
	function automatic logic [RATE_W-1:0] rounded_rate(input logic [127:0] num,
			input logic [TS_W-1:0] span);
		logic [127:0] d;
		logic [127:0] q;
		logic [127:0] r;
		d = 128'(span);
		q = num / d;
		r = num % d;
		if (r >= d - r)
			q = q + 128'd1;
		if (q > 128'(RATE_MAX))
			return RATE_MAX;
		return q[RATE_W-1:0];
	endfunction

	function automatic window_rates_t close_window();
		window_rates_t w;
		logic [TS_W-1:0] span;
		logic [127:0] num_up;
		logic [127:0] num_down;
		span = win_last - win_start;
		w.mid = win_start + (span >> 1);
		w.valid = (span >= 64'(min_span));
		w.up = '0;
		w.down = '0;
		w.total = '0;
		if (w.valid && span == '0) begin
			w.up = (up_bytes != '0 && scale != '0) ? RATE_MAX : '0;
			w.down = (down_bytes != '0 && scale != '0) ? RATE_MAX : '0;
			w.total = (w.up != '0 || w.down != '0) ? RATE_MAX : '0;
		end else if (w.valid) begin
			num_up = 128'(up_bytes) * 128'(scale);
			num_down = 128'(down_bytes) * 128'(scale);
			w.up = rounded_rate(num_up, span);
			w.down = rounded_rate(num_down, span);
			w.total = rounded_rate(num_up + num_down, span);
		end
		return w;
	endfunction

	function automatic logic [SUM_W-1:0] add_bytes(input logic [SUM_W-1:0] sum,
			input logic [LEN_W-1:0] len);
		logic [SUM_W:0] wide;
		wide = {1'b0, sum} + (SUM_W + 1)'(len);
		return wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
	endfunction

	task automatic check_field(input string name, input logic [TS_W-1:0] exp_val,
			input logic [TS_W-1:0] act_val);
		if (exp_val !== act_val) begin
			fails++;
			$display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len = WINDOW_USEC_RST;
			min_span = MIN_SPAN_USEC_RST;
			scale = RATE_SCALE_RST;
			win_start = '0;
			win_last = '0;
			up_bytes = '0;
			down_bytes = '0;
			win_open = 1'b0;
			pending_windows.delete();
			outstanding <= 0;
			fail_count <= fails;
		end else begin
			// result side first: anything taken now was predicted at an earlier edge
			if (out_valid && !out_stall) begin
				got = '{mid_time_usec, rate_upstream, rate_downstream, rate_total,
					span_valid};
				if (pending_windows.size() == 0) begin
					fails++;
					$display("%0t: result expected none actual %h %h %h %h %b", $time,
						got.mid, got.up, got.down, got.total, got.valid);
				end else begin
					want = pending_windows.pop_front();
					check_field("mid_time_usec", want.mid, got.mid);
					check_field("rate_upstream", 64'(want.up), 64'(got.up));
					check_field("rate_downstream", 64'(want.down), 64'(got.down));
					check_field("rate_total", 64'(want.total), 64'(got.total));
					check_field("span_valid", 64'(want.valid), 64'(got.valid));
				end
			end
			if (in_valid && !in_stall) begin
				if (func == FUNC_FLUSH) begin
					if (win_open) begin
						pending_windows.push_back(close_window());
						win_open = 1'b0;
					end
				end else begin
					if (!win_open || timestamp_usec - win_start >= 64'(window_len)) begin
						if (win_open)
							pending_windows.push_back(close_window());
						win_open = 1'b1;
						win_start = timestamp_usec;
						up_bytes = '0;
						down_bytes = '0;
					end
					win_last = timestamp_usec;
					if (upstream)
						up_bytes = add_bytes(up_bytes, packet_bytes);
					else
						down_bytes = add_bytes(down_bytes, packet_bytes);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_USEC: window_len = cfg_data;
					CFG_MIN_SPAN_USEC: min_span = cfg_data;
					CFG_RATE_SCALE: scale = cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
			outstanding <= pending_windows.size();
			fail_count <= fails;
		end
	end

endmodule

// File: tb/windowed_flow_bandwidth_meter_tb.sv
// drives packet records and flushes into the meter, drains the result channel and
// gives the verdict; all checking lives in meter_checker
module windowed_flow_bandwidth_meter_tb;
	import wfbm_pkg::*;

	localparam logic FUNC_PACKET = ~FUNC_FLUSH;
	// cycles to let the block go quiet before a register write and at the end
	localparam int SETTLE_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 112;
	localparam int PHASES = 8;

	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_RANDOM,
		DRAIN_HEAVY
	} drain_mode_t;

	// every input known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_WINDOW_USEC;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic func = 1'b0;
	logic [TS_W-1:0] timestamp_usec = '0;
	logic [LEN_W-1:0] packet_bytes = '0;
	logic upstream = 1'b0;
	logic out_stall = 1'b0;

	logic in_stall;
	logic out_valid;
	logic [TS_W-1:0] mid_time_usec;
	logic [RATE_W-1:0] rate_upstream;
	logic [RATE_W-1:0] rate_downstream;
	logic [RATE_W-1:0] rate_total;
	logic span_valid;
	int fail_count;
	int outstanding;

	// stimulus state
	int burst_left = 0;
	drain_mode_t drain_mode = DRAIN_FREE;
	int drain_left = 0;
	logic [TS_W-1:0] now_usec;
	logic [CFG_W-1:0] win_len;
	logic [CFG_W-1:0] min_span;
	logic [SCALE_W-1:0] scale;
	logic [CFG_W-1:0] step_cap;
	int roll;

	always #5 clk = ~clk;

	windowed_flow_bandwidth_meter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.timestamp_usec(timestamp_usec),
		.packet_bytes(packet_bytes),
		.upstream(upstream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mid_time_usec(mid_time_usec),
		.rate_upstream(rate_upstream),
		.rate_downstream(rate_downstream),
		.rate_total(rate_total),
		.span_valid(span_valid)
	);

	meter_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.timestamp_usec(timestamp_usec),
		.packet_bytes(packet_bytes),
		.upstream(upstream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mid_time_usec(mid_time_usec),
		.rate_upstream(rate_upstream),
		.rate_downstream(rate_downstream),
		.rate_total(rate_total),
		.span_valid(span_valid),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// result side: the stall pattern switches between free, coin-flip and heavy
	// stretches so stalls land on every phase of the divider's work
	always @(posedge clk) begin
		if (drain_left == 0) begin
			drain_mode <= drain_mode_t'($urandom_range(0, 2));
			drain_left <= $urandom_range(16, 160);
		end else begin
			drain_left <= drain_left - 1;
		end
		case (drain_mode)
			DRAIN_FREE: out_stall <= 1'b0;
			DRAIN_RANDOM: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// one record transfer; bursts of random length, random gaps between them
	task automatic send_record(input logic f, input logic [TS_W-1:0] ts,
			input logic [LEN_W-1:0] len, input logic up);
		int gap;
		in_valid <= 1'b1;
		func <= f;
		timestamp_usec <= ts;
		packet_bytes <= len;
		upstream <= up;
		// held until the block takes it
		do @(posedge clk); while (in_stall);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
	endtask

	task automatic packet(input logic [TS_W-1:0] ts, input logic [LEN_W-1:0] len,
			input logic up);
		send_record(FUNC_PACKET, ts, len, up);
	endtask

	// flush payload is don't-care, so it carries random bits
	task automatic flush();
		send_record(FUNC_FLUSH, {$urandom, $urandom}, LEN_W'($urandom), 1'($urandom));
	endtask

	// wait for every predicted result, then let the divider drain
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// scale word carries junk above bit 23 to exercise the masking
	task automatic program_meter(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] span_min,
			input logic [SCALE_W-1:0] mult);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WINDOW_USEC;
		cfg_data <= win;
		@(posedge clk);
		cfg_index <= CFG_MIN_SPAN_USEC;
		cfg_data <= span_min;
		@(posedge clk);
		cfg_index <= CFG_RATE_SCALE;
		cfg_data <= {8'($urandom), mult};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: flush with nothing open, one valid window closed by a
		// late packet, then a short window closed by flush with an invalid span
		flush();
		packet(64'd0, 16'hFFFF, 1'b1);
		packet(64'd500000, 16'd0, 1'b0);
		packet(64'd950000, 16'd1, 1'b1);
		packet(64'd1000000, 16'hFFFF, 1'b0);
		packet(64'd1000100, 16'd1500, 1'b0);
		flush();
		flush();

		// zero spans count as valid, rates saturate; timestamps at the top of the
		// range and one step backwards through the wrap
		settle();
		program_meter(32'd1, 32'd0, 24'hFF_FFFF);
		packet(64'hFFFF_FFFF_FFFF_FFF0, 16'd100, 1'b1);
		flush();
		packet(64'hFFFF_FFFF_FFFF_FFF0, 16'd0, 1'b0);
		flush();
		packet(64'hFFFF_FFFF_FFFF_FFF0, 16'hFFFF, 1'b1);
		packet(64'hFFFF_FFFF_FFFF_FFF1, 16'hFFFF, 1'b0);
		packet(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b0);
		packet(64'd5, 16'd9, 1'b1);

		// widest window and span floor, smallest scale; a backwards timestamp
		// closes the window through the wrapped difference
		settle();
		program_meter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd1);
		packet(64'd10, 16'hFFFF, 1'b1);
		packet(64'd20, 16'd7, 1'b0);
		packet(64'd3, 16'd1, 1'b1);
		packet(64'd3 + 64'hFFFF_FFFF, 16'd2, 1'b0);
		packet(64'd3 + 64'hFFFF_FFFF + 64'hFFFF_FFFE, 16'd1, 1'b1);
		flush();

		// random phases, each under its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					win_len = WINDOW_USEC_RST;
					min_span = MIN_SPAN_USEC_RST;
					scale = RATE_SCALE_RST;
				end
				1: begin
					win_len = 32'd1;
					min_span = 32'd0;
					scale = 24'd1;
				end
				2: begin
					win_len = 32'hFFFF_FFFF;
					min_span = 32'd0;
					scale = 24'hFF_FFFF;
				end
				4: begin
					win_len = $urandom_range(1, 32'hFFFF_FFFF);
					min_span = $urandom;
					scale = SCALE_W'($urandom_range(1, 24'hFF_FFFF));
				end
				5: begin
					win_len = $urandom_range(1, 300);
					min_span = 32'd0;
					scale = SCALE_W'($urandom_range(1, 255));
				end
				6: begin
					// floor mostly above the window: mostly invalid spans
					win_len = $urandom_range(100, 100000);
					min_span = $urandom;
					scale = SCALE_W'($urandom_range(1, 24'hFF_FFFF));
				end
				default: begin
					win_len = $urandom_range(2, 20000);
					min_span = $urandom_range(0, win_len);
					scale = SCALE_W'($urandom_range(1, 24'hFF_FFFF));
				end
			endcase
			settle();
			program_meter(win_len, min_span, scale);
			step_cap = (win_len >> 1) + 32'd1;
			// the widest window starts just below the wrap so it gets crossed
			if (phase == 2)
				now_usec = 64'hFFFF_FFFF_0000_0000 | 64'($urandom_range(0, 32'hFFFF));
			else
				now_usec = {$urandom, $urandom};

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					flush();
				end else begin
					// mostly forward steps inside the window, some repeats, some
					// long steps and a few arbitrary jumps that may go backwards
					if (roll < 11)
						now_usec = {$urandom, $urandom};
					else if (roll < 18)
						now_usec = now_usec + 64'(win_len) + 64'($urandom_range(0, step_cap));
					else if (roll >= 36)
						now_usec = now_usec + 64'($urandom_range(0, step_cap));
					case ($urandom_range(0, 9))
						0: packet(now_usec, 16'd0, 1'($urandom));
						1: packet(now_usec, 16'hFFFF, 1'($urandom));
						default: packet(now_usec, LEN_W'($urandom), 1'($urandom));
					endcase
				end
			end
		end

		settle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
sv/wfbm_pkg.sv
sv/wfbm_ctrl.sv
sv/wfbm_dpath.sv
sv/windowed_flow_bandwidth_meter.sv
tb/meter_checker.sv
tb/windowed_flow_bandwidth_meter_tb.sv
